// ===== design/jtsm_pkg.sv =====
`timescale 1ns / 1ps

package jtsm_pkg;

    localparam int SHIFT_W = 64;
    localparam int COUNT_W = 7;
    localparam int STATE_W = 4;
    localparam int TICK_W  = 3;
    localparam int IDX_W   = $clog2(SHIFT_W);

    localparam logic [1:0] KIND_RESET = 2'd0;
    localparam logic [1:0] KIND_IR    = 2'd1;
    localparam logic [1:0] KIND_DR    = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    localparam logic [STATE_W-1:0] TAP_TLR       = 4'd0;
    localparam logic [STATE_W-1:0] TAP_RTI       = 4'd1;
    localparam logic [STATE_W-1:0] TAP_SEL_DR    = 4'd2;
    localparam logic [STATE_W-1:0] TAP_CAP_DR    = 4'd3;
    localparam logic [STATE_W-1:0] TAP_SHIFT_DR  = 4'd4;
    localparam logic [STATE_W-1:0] TAP_EXIT1_DR  = 4'd5;
    localparam logic [STATE_W-1:0] TAP_PAUSE_DR  = 4'd6;
    localparam logic [STATE_W-1:0] TAP_EXIT2_DR  = 4'd7;
    localparam logic [STATE_W-1:0] TAP_UPDATE_DR = 4'd8;
    localparam logic [STATE_W-1:0] TAP_SEL_IR    = 4'd9;
    localparam logic [STATE_W-1:0] TAP_CAP_IR    = 4'd10;
    localparam logic [STATE_W-1:0] TAP_SHIFT_IR  = 4'd11;
    localparam logic [STATE_W-1:0] TAP_EXIT1_IR  = 4'd12;
    localparam logic [STATE_W-1:0] TAP_PAUSE_IR  = 4'd13;
    localparam logic [STATE_W-1:0] TAP_EXIT2_IR  = 4'd14;
    localparam logic [STATE_W-1:0] TAP_UPDATE_IR = 4'd15;

    // First TMS bit of a shortest path toward each walk target, one bit per
    // current state (ties resolved to TMS=0).
    localparam logic [15:0] TMS_TO_SHIFT_DR  = 16'hFF42;
    localparam logic [15:0] TMS_TO_SHIFT_IR  = 16'hA1FE;
    localparam logic [15:0] TMS_TO_UPDATE_DR = 16'hFFFA;
    localparam logic [15:0] TMS_TO_UPDATE_IR = 16'hFDFE;

    typedef struct packed {
        logic                 mode;
        logic [1:0]           command_kind;
        logic [SHIFT_W-1:0]   shift_in;
        logic [COUNT_W-1:0]   bit_count;
        logic                 tdo_sample;
    } t_in_word;

    typedef struct packed {
        logic                 tms_level;
        logic                 tdi_level;
        logic                 pulse_tck;
        logic                 busy_res;
        logic                 done_res;
        logic                 error;
        logic [SHIFT_W-1:0]   captured;
        logic [STATE_W-1:0]   tap_state_now;
    } t_out_word;

    typedef struct packed {
        logic [STATE_W-1:0]   tap_state;
        logic [1:0]           active_kind;
        logic                 running;
        logic [SHIFT_W-1:0]   out_shift;
        logic [SHIFT_W-1:0]   in_capture;
        logic [COUNT_W-1:0]   bits_left;
        logic [TICK_W-1:0]    reset_ticks;
        logic [COUNT_W-1:0]   bit_index;
    } t_tap_regs;

    function automatic logic [STATE_W-1:0] tap_next(
        input logic [STATE_W-1:0] state,
        input logic               tms
    );
        logic [STATE_W-1:0] nxt;
        case (state)
            TAP_TLR:       nxt = tms ? TAP_TLR       : TAP_RTI;
            TAP_RTI:       nxt = tms ? TAP_SEL_DR    : TAP_RTI;
            TAP_SEL_DR:    nxt = tms ? TAP_SEL_IR    : TAP_CAP_DR;
            TAP_CAP_DR:    nxt = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
            TAP_SHIFT_DR:  nxt = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
            TAP_EXIT1_DR:  nxt = tms ? TAP_UPDATE_DR : TAP_PAUSE_DR;
            TAP_PAUSE_DR:  nxt = tms ? TAP_EXIT2_DR  : TAP_PAUSE_DR;
            TAP_EXIT2_DR:  nxt = tms ? TAP_UPDATE_DR : TAP_SHIFT_DR;
            TAP_UPDATE_DR: nxt = tms ? TAP_SEL_DR    : TAP_RTI;
            TAP_SEL_IR:    nxt = tms ? TAP_TLR       : TAP_CAP_IR;
            TAP_CAP_IR:    nxt = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
            TAP_SHIFT_IR:  nxt = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
            TAP_EXIT1_IR:  nxt = tms ? TAP_UPDATE_IR : TAP_PAUSE_IR;
            TAP_PAUSE_IR:  nxt = tms ? TAP_EXIT2_IR  : TAP_PAUSE_IR;
            TAP_EXIT2_IR:  nxt = tms ? TAP_UPDATE_IR : TAP_SHIFT_IR;
            TAP_UPDATE_IR: nxt = tms ? TAP_SEL_DR    : TAP_RTI;
            default:       nxt = TAP_TLR;
        endcase
        return nxt;
    endfunction

    function automatic logic first_tms(
        input logic [STATE_W-1:0] from,
        input logic [STATE_W-1:0] target
    );
        logic tms;
        case (target)
            TAP_SHIFT_DR:  tms = TMS_TO_SHIFT_DR[from];
            TAP_SHIFT_IR:  tms = TMS_TO_SHIFT_IR[from];
            TAP_UPDATE_DR: tms = TMS_TO_UPDATE_DR[from];
            TAP_UPDATE_IR: tms = TMS_TO_UPDATE_IR[from];
            default:       tms = 1'b0;
        endcase
        return tms;
    endfunction

endpackage

// ===== design/jtsm_step.sv =====
`timescale 1ns / 1ps

module jtsm_step #(
    parameter int MAX_SHIFT_BITS  = 64,
    parameter int RESET_TMS_TICKS = 5
) (
    input  jtsm_pkg::t_in_word  i_word,
    input  jtsm_pkg::t_tap_regs i_cur,
    output jtsm_pkg::t_tap_regs o_nxt,
    output jtsm_pkg::t_out_word o_word
);

    localparam logic [jtsm_pkg::TICK_W-1:0] RESET_LAST =
        jtsm_pkg::TICK_W'(RESET_TMS_TICKS - 1);
    localparam logic [jtsm_pkg::COUNT_W-1:0] COUNT_MAX =
        jtsm_pkg::COUNT_W'(MAX_SHIFT_BITS);

    logic                                 tms;
    logic                                 tdi;
    logic                                 pulse;
    logic                                 done;
    logic                                 err;
    logic [jtsm_pkg::SHIFT_W-1:0]         cap;
    logic [jtsm_pkg::STATE_W-1:0]         sh_state;
    logic [jtsm_pkg::STATE_W-1:0]         up_state;
    jtsm_pkg::t_tap_regs                  nxt;

    always_comb begin
        nxt   = i_cur;
        tms   = 1'b0;
        tdi   = 1'b0;
        pulse = 1'b0;
        done  = 1'b0;
        err   = 1'b0;
        cap   = '0;
        sh_state = (i_cur.active_kind == jtsm_pkg::KIND_IR) ?
                   jtsm_pkg::TAP_SHIFT_IR : jtsm_pkg::TAP_SHIFT_DR;
        up_state = (i_cur.active_kind == jtsm_pkg::KIND_IR) ?
                   jtsm_pkg::TAP_UPDATE_IR : jtsm_pkg::TAP_UPDATE_DR;

        if (i_word.mode) begin
            if (i_cur.running || i_word.command_kind == jtsm_pkg::KIND_BAD ||
                (i_word.command_kind != jtsm_pkg::KIND_RESET &&
                 (i_word.bit_count == '0 || i_word.bit_count > COUNT_MAX))) begin
                err = 1'b1;
            end else begin
                nxt.active_kind = i_word.command_kind;
                nxt.running     = 1'b1;
                nxt.in_capture  = '0;
                nxt.bit_index   = '0;
                if (i_word.command_kind == jtsm_pkg::KIND_RESET) begin
                    nxt.reset_ticks = RESET_LAST;
                    nxt.bits_left   = jtsm_pkg::COUNT_W'(1);
                end else begin
                    nxt.out_shift = i_word.shift_in;
                    nxt.bits_left = i_word.bit_count;
                end
            end
        end else if (i_cur.running) begin
            pulse = 1'b1;
            if (i_cur.active_kind == jtsm_pkg::KIND_RESET) begin
                // TMS=1 run, then one TMS=0 tick lands in Run-Test/Idle
                if (i_cur.bits_left != '0) begin
                    tms = 1'b1;
                    if (i_cur.reset_ticks == '0) begin
                        nxt.bits_left = '0;
                    end else begin
                        nxt.reset_ticks = i_cur.reset_ticks - 1'b1;
                    end
                end else begin
                    done = 1'b1;
                end
                nxt.tap_state = jtsm_pkg::tap_next(i_cur.tap_state, tms);
            end else begin
                if (i_cur.bits_left != '0 && i_cur.tap_state == sh_state) begin
                    tdi = i_cur.out_shift[0];
                    tms = (i_cur.bits_left == jtsm_pkg::COUNT_W'(1));
                    if (i_cur.active_kind == jtsm_pkg::KIND_DR) begin
                        nxt.in_capture = i_cur.in_capture |
                            (jtsm_pkg::SHIFT_W'(i_word.tdo_sample)
                             << i_cur.bit_index[jtsm_pkg::IDX_W-1:0]);
                    end
                    nxt.out_shift = i_cur.out_shift >> 1;
                    nxt.bit_index = i_cur.bit_index + 1'b1;
                    nxt.bits_left = i_cur.bits_left - 1'b1;
                end else begin
                    tms = jtsm_pkg::first_tms(i_cur.tap_state,
                        (i_cur.bits_left != '0) ? sh_state : up_state);
                end
                nxt.tap_state = jtsm_pkg::tap_next(i_cur.tap_state, tms);
                if (nxt.bits_left == '0 && nxt.tap_state == up_state) begin
                    done = 1'b1;
                end
            end
            if (done) begin
                nxt.running = 1'b0;
                if (i_cur.active_kind == jtsm_pkg::KIND_DR) begin
                    cap = nxt.in_capture;
                end
            end
        end

        o_nxt                = nxt;
        o_word.tms_level     = tms;
        o_word.tdi_level     = tdi;
        o_word.pulse_tck     = pulse;
        o_word.busy_res      = nxt.running;
        o_word.done_res      = done;
        o_word.error         = err;
        o_word.captured      = cap;
        o_word.tap_state_now = nxt.tap_state;
    end

endmodule

// ===== design/jtag_tap_shift_master.sv =====
`timescale 1ns / 1ps
// An accepted input word passes the input register and then the result register.
// Throughput: one word per cycle while i_out_ready does not stall the result register;
//   the TAP tracking state updates in one pass between the input and result registers.
// Reset (i_rst_n low, synchronous): TAP tracked in Test-Logic-Reset, no command
//   running, both pipeline registers empty.

module jtag_tap_shift_master #(
    parameter int MAX_SHIFT_BITS  = 64,
    parameter int RESET_TMS_TICKS = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  jtsm_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output jtsm_pkg::t_out_word o_out_word
);

    logic                r_in_valid;
    jtsm_pkg::t_in_word  r_in_word;
    jtsm_pkg::t_tap_regs r_regs;
    jtsm_pkg::t_tap_regs n_regs;
    logic                r_out_valid;
    jtsm_pkg::t_out_word r_out_word;
    jtsm_pkg::t_out_word n_out_word;
    logic                w_advance;

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    jtsm_step #(
        .MAX_SHIFT_BITS  (MAX_SHIFT_BITS),
        .RESET_TMS_TICKS (RESET_TMS_TICKS)
    ) u_step (
        .i_word (r_in_word),
        .i_cur  (r_regs),
        .o_nxt  (n_regs),
        .o_word (n_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_regs      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_regs      <= n_regs;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (w_advance) begin
            r_out_word <= n_out_word;
        end
    end

endmodule
